>>> hw/rtl/voxel_opacity_error_shader_defines.svh
// Assertion macros for the voxel opacity/error shader checkers.
// Included by the checker file; needs nothing else.
`ifndef VOXEL_OPACITY_ERROR_SHADER_DEFINES_SVH
`define VOXEL_OPACITY_ERROR_SHADER_DEFINES_SVH

// Clocked check, switched off while reset is high
`define VOE_ASSERT_RST(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("voe assertion failed");

// Clocked check that also runs during reset
`define VOE_ASSERT_CLK(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("voe assertion failed");

`endif

>>> hw/rtl/voe_pkg.sv
// Shared types and constants of the voxel opacity/error shader.
// No dependencies; used by every other file of the block but the defines header.
`timescale 1ns / 1ps

package voe_pkg;

   localparam int unsigned DATA_W       = 24;  // Q8.16 densities
   localparam int unsigned COLOR_W      = 8;
   localparam int unsigned FRAC_W       = 32;  // Q0.32 exponent fraction
   localparam int unsigned PROD_W       = 2 * DATA_W;
   localparam int unsigned REM_W        = 37;  // holds anything below 33 * ln2
   localparam int unsigned N_W          = 6;   // shift count, 0..32
   localparam int unsigned K_W          = 4;   // Taylor term index, up to 14
   localparam int unsigned TAYLOR_TERMS = 14;
   localparam int unsigned N_LIMIT      = 33;  // shift of 33 or more flushes to zero

   localparam int unsigned ERR_LAT = 11;  // voe_err input to output
   localparam int unsigned EXP_LAT = 49;  // voe_exp input to output

   localparam logic [DATA_W-1:0]  ML_RESET  = DATA_W'(65536);
   localparam logic [FRAC_W-1:0]  LN2_Q32   = 32'd2977044472;
   localparam logic [FRAC_W:0]    Q_ONE     = {1'b1, {FRAC_W{1'b0}}};
   localparam logic [PROD_W-1:0]  BIG_LIMIT = PROD_W'(LN2_Q32) * PROD_W'(N_LIMIT);
   localparam logic [COLOR_W-1:0] COLOR_MAX = {COLOR_W{1'b1}};
   localparam logic [1:0]         SKID_DEPTH = 2'd2;

   typedef struct packed {
      logic [DATA_W-1:0] density;
      logic [DATA_W-1:0] reference;
      logic              last_voxel;
   } voe_req_type;

   typedef struct packed {
      logic [COLOR_W-1:0] red;
      logic [COLOR_W-1:0] blue;
      logic [COLOR_W-1:0] alpha;
      logic               last_out;
   } voe_rsp_type;

   typedef struct packed {
      logic [COLOR_W-1:0] red;
      logic [COLOR_W-1:0] blue;
   } voe_err_type;

   // Pipeline tail to output buffer
   typedef struct packed {
      logic        valid;
      voe_rsp_type data;
   } voe_push_type;

endpackage

>>> hw/rtl/voxel_opacity_error_shader.sv
// Voxel opacity/error shader top: marching_length register, valid line, output buffer.
// Depends on voe_pkg, voe_err, voe_exp and voe_skid.
// A req transaction passes the 49-stage opacity pipeline (three stages per Taylor term)
// and then the output buffer before rsp_valid rises.
// Throughput one voxel per cycle; a full output buffer freezes the pipe and raises req_stall.
// Synchronous active-high reset empties pipeline and buffer and sets marching_length to 1.0.
`timescale 1ns / 1ps

module voxel_opacity_error_shader (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  voe_pkg::voe_req_type        req_data,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output voe_pkg::voe_rsp_type        rsp_data,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [voe_pkg::DATA_W-1:0]  csr_data
);

   localparam int unsigned Lat = voe_pkg::EXP_LAT;
   localparam int unsigned Gap = voe_pkg::EXP_LAT - voe_pkg::ERR_LAT;

   logic [voe_pkg::DATA_W-1:0]  ml_ff;
   logic                        enable;
   logic                        skid_ready;
   logic [Lat-1:0]              valid_ff;
   logic [Lat-1:0]              valid_in;
   logic [Lat-1:0]              last_ff;
   voe_pkg::voe_err_type        err_out;
   voe_pkg::voe_err_type        err_dly_ff [Gap];
   logic [voe_pkg::COLOR_W-1:0] alpha_out;
   voe_pkg::voe_push_type       push;

   // marching_length register, always ready
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         ml_ff <= voe_pkg::ML_RESET;
      end else if (csr_valid && csr_ready) begin
         ml_ff <= csr_data;
      end
   end

   // Whole pipeline moves while the output buffer has room
   assign enable    = skid_ready;
   assign req_stall = !skid_ready;

   // Valid bits and last flag travel alongside the data
   assign valid_in = {valid_ff[Lat-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (enable) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         last_ff <= {last_ff[Lat-2:0], req_data.last_voxel};
      end
   end

   voe_err u_err (
      .clock     (clock),
      .enable    (enable),
      .density   (req_data.density),
      .reference (req_data.reference),
      .err       (err_out)
   );

   voe_exp u_exp (
      .clock           (clock),
      .enable          (enable),
      .density         (req_data.density),
      .marching_length (ml_ff),
      .alpha           (alpha_out)
   );

   // Line up the shorter error path with the opacity path
   always_ff @(posedge clock) begin
      if (enable) begin
         err_dly_ff[0] <= err_out;
         for (int i = 1; i < Gap; i++) begin
            err_dly_ff[i] <= err_dly_ff[i-1];
         end
      end
   end

   always_comb begin
      push.valid         = enable && valid_ff[Lat-1];
      push.data.red      = err_dly_ff[Gap-1].red;
      push.data.blue     = err_dly_ff[Gap-1].blue;
      push.data.alpha    = alpha_out;
      push.data.last_out = last_ff[Lat-1];
   end

   voe_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .ready     (skid_ready),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

>>> hw/rtl/voe_err.sv
// Relative error pipeline: red and blue from |density - reference| / reference.
// Depends on voe_pkg; 11 stages, advances when enable is high.
`timescale 1ns / 1ps

module voe_err (
   input  logic                          clock,
   input  logic                          enable,
   input  logic [voe_pkg::DATA_W-1:0]    density,
   input  logic [voe_pkg::DATA_W-1:0]    reference,
   output voe_pkg::voe_err_type          err
);

   localparam int unsigned DataW  = voe_pkg::DATA_W;
   localparam int unsigned ColorW = voe_pkg::COLOR_W;
   localparam int unsigned NumW   = DataW + ColorW;

   typedef struct packed {
      logic [DataW-1:0]  r;
      logic              zero_r;
      logic              both_zero;
      logic              ge;      // error of one or more
      logic [ColorW-1:0] low;     // low byte of 255 * diff
   } side_type;

   // Stage 1: absolute difference
   logic [DataW-1:0] diff_ff;
   logic [DataW-1:0] ref_ff;

   always_ff @(posedge clock) begin
      if (enable) begin
         diff_ff <= (density > reference) ? density - reference : reference - density;
         ref_ff  <= reference;
      end
   end

   // Stage 2: numerator 255 * diff, saturation and zero flags
   logic [NumW-1:0]  num;
   side_type         s2_side_ff;
   logic [DataW-1:0] s2_part_ff;

   assign num = {diff_ff, {ColorW{1'b0}}} - NumW'(diff_ff);

   always_ff @(posedge clock) begin
      if (enable) begin
         s2_side_ff.r         <= ref_ff;
         s2_side_ff.zero_r    <= (ref_ff == '0);
         s2_side_ff.both_zero <= (ref_ff == '0) && (diff_ff == '0);
         s2_side_ff.ge        <= (diff_ff >= ref_ff);
         s2_side_ff.low       <= num[ColorW-1:0];
         s2_part_ff           <= num[NumW-1:ColorW];
      end
   end

   // Stages 3..10: restoring division, one quotient bit per stage
   side_type          dv_side_ff [ColorW];
   logic [DataW-1:0]  dv_part_ff [ColorW];
   logic [ColorW-1:0] dv_q_ff    [ColorW];

   for (genvar s = 0; s < ColorW; s++) begin : g_div
      side_type          side_src;
      logic [DataW-1:0]  part_src;
      logic [ColorW-1:0] q_src;
      logic [DataW:0]    cand;
      logic [DataW:0]    cand_sub;
      logic              take;

      if (s == 0) begin : g_first
         assign side_src = s2_side_ff;
         assign part_src = s2_part_ff;
         assign q_src    = '0;
      end else begin : g_next
         assign side_src = dv_side_ff[s-1];
         assign part_src = dv_part_ff[s-1];
         assign q_src    = dv_q_ff[s-1];
      end

      assign cand     = {part_src, side_src.low[ColorW-1-s]};
      assign cand_sub = cand - {1'b0, side_src.r};
      assign take     = (cand >= {1'b0, side_src.r});

      always_ff @(posedge clock) begin
         if (enable) begin
            dv_side_ff[s] <= side_src;
            dv_part_ff[s] <= take ? cand_sub[DataW-1:0] : cand[DataW-1:0];
            dv_q_ff[s]    <= {q_src[ColorW-2:0], take};
         end
      end
   end

   // Stage 11: blue = 255 - ceil(255 * err), special cases override
   side_type             fin_side;
   logic [DataW-1:0]     fin_part;
   logic [ColorW-1:0]    fin_q;
   logic [ColorW-1:0]    blue_calc;
   voe_pkg::voe_err_type err_ff;

   assign fin_side  = dv_side_ff[ColorW-1];
   assign fin_part  = dv_part_ff[ColorW-1];
   assign fin_q     = dv_q_ff[ColorW-1];
   assign blue_calc = voe_pkg::COLOR_MAX - fin_q - ColorW'(fin_part != '0);

   always_ff @(posedge clock) begin
      if (enable) begin
         if (fin_side.zero_r) begin
            err_ff.red  <= fin_side.both_zero ? '0 : voe_pkg::COLOR_MAX;
            err_ff.blue <= fin_side.both_zero ? voe_pkg::COLOR_MAX : '0;
         end else if (fin_side.ge) begin
            err_ff.red  <= voe_pkg::COLOR_MAX;
            err_ff.blue <= '0;
         end else begin
            err_ff.red  <= fin_q;
            err_ff.blue <= blue_calc;
         end
      end
   end

   assign err = err_ff;

endmodule

>>> hw/rtl/voe_exp.sv
// Opacity pipeline: alpha = 255 * (1 - exp(-density * marching_length)).
// Depends on voe_pkg; 49 stages, advances when enable is high.
`timescale 1ns / 1ps

module voe_exp (
   input  logic                          clock,
   input  logic                          enable,
   input  logic [voe_pkg::DATA_W-1:0]    density,
   input  logic [voe_pkg::DATA_W-1:0]    marching_length,
   output logic [voe_pkg::COLOR_W-1:0]   alpha
);

   localparam int unsigned FracW   = voe_pkg::FRAC_W;
   localparam int unsigned AccW    = FracW + 1;
   localparam int unsigned DblW    = 2 * FracW;
   localparam int unsigned KW      = voe_pkg::K_W;
   localparam int unsigned BackW   = FracW + KW;
   localparam int unsigned ProdW   = voe_pkg::PROD_W;
   localparam int unsigned RemW    = voe_pkg::REM_W;
   localparam int unsigned NW      = voe_pkg::N_W;
   localparam int unsigned ColorW  = voe_pkg::COLOR_W;
   localparam int unsigned RrSteps = voe_pkg::N_W;
   localparam int unsigned FirstK  = 2;
   localparam int unsigned LastK   = voe_pkg::TAYLOR_TERMS;

   // Values that ride along the series stages
   typedef struct packed {
      logic [FracW-1:0] r;
      logic [NW-1:0]    n;
      logic             big;
      logic [AccW-1:0]  acc;
   } side_type;

   // Stage 1: exponent x = density * marching_length, Q16.32
   logic [ProdW-1:0] prod_ff;

   always_ff @(posedge clock) begin
      if (enable) begin
         prod_ff <= ProdW'(density) * ProdW'(marching_length);
      end
   end

   // Stages 2..7: n = x / ln2 and r = x mod ln2, one bit of n per stage
   logic [RemW-1:0] rr_rem_ff [RrSteps];
   logic [NW-1:0]   rr_n_ff   [RrSteps];
   logic            rr_big_ff [RrSteps];

   for (genvar s = 0; s < RrSteps; s++) begin : g_rr
      localparam logic [RemW-1:0] Sub = RemW'(voe_pkg::LN2_Q32) << (RrSteps - 1 - s);
      logic [RemW-1:0] rem_src;
      logic [NW-1:0]   n_src;
      logic            big_src;
      logic            take;

      if (s == 0) begin : g_first
         assign rem_src = prod_ff[RemW-1:0];
         assign n_src   = '0;
         assign big_src = (prod_ff >= voe_pkg::BIG_LIMIT);
      end else begin : g_next
         assign rem_src = rr_rem_ff[s-1];
         assign n_src   = rr_n_ff[s-1];
         assign big_src = rr_big_ff[s-1];
      end

      assign take = (rem_src >= Sub);

      always_ff @(posedge clock) begin
         if (enable) begin
            rr_rem_ff[s] <= take ? rem_src - Sub : rem_src;
            rr_n_ff[s]   <= {n_src[NW-2:0], take};
            rr_big_ff[s] <= big_src;
         end
      end
   end

   // Taylor series, three stages per term k = 2..14:
   //   A: accumulate term k-1, multiply term k-1 by r
   //   B: quotient estimate by reciprocal of k
   //   C: one-step correction of the estimate
   // The first term is r itself; the final A stage only accumulates term 14.
   side_type         a_side_ff [FirstK:LastK+1];
   logic [FracW-1:0] a_p_ff    [FirstK:LastK];
   side_type         b_side_ff [FirstK:LastK];
   logic [FracW-1:0] b_p_ff    [FirstK:LastK];
   logic [FracW-1:0] b_q_ff    [FirstK:LastK];
   side_type         c_side_ff [FirstK:LastK];
   logic [FracW-1:0] c_term_ff [FirstK:LastK];

   for (genvar k = FirstK; k <= LastK + 1; k++) begin : g_acc
      localparam bit Subtract = (k % 2 == 0);  // term k-1 odd
      side_type         side_src;
      side_type         side_new;
      logic [FracW-1:0] term_src;

      if (k == FirstK) begin : g_first
         always_comb begin
            side_src.r   = rr_rem_ff[RrSteps-1][FracW-1:0];
            side_src.n   = rr_n_ff[RrSteps-1];
            side_src.big = rr_big_ff[RrSteps-1];
            side_src.acc = voe_pkg::Q_ONE;
         end
         assign term_src = rr_rem_ff[RrSteps-1][FracW-1:0];
      end else begin : g_next
         assign side_src = c_side_ff[k-1];
         assign term_src = c_term_ff[k-1];
      end

      always_comb begin
         side_new = side_src;
         if (Subtract) begin
            side_new.acc = side_src.acc - {1'b0, term_src};
         end else begin
            side_new.acc = side_src.acc + {1'b0, term_src};
         end
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            a_side_ff[k] <= side_new;
         end
      end

      if (k <= LastK) begin : g_mul
         logic [DblW-1:0] prod;

         assign prod = DblW'(term_src) * DblW'(side_src.r);

         always_ff @(posedge clock) begin
            if (enable) begin
               a_p_ff[k] <= prod[DblW-1:FracW];
            end
         end
      end
   end

   for (genvar k = FirstK; k <= LastK; k++) begin : g_div
      localparam logic [AccW-1:0]  RecipFull = voe_pkg::Q_ONE / AccW'(k);
      localparam logic [FracW-1:0] Recip     = RecipFull[FracW-1:0];
      localparam logic [KW-1:0]    KVal      = KW'(k);
      logic [DblW-1:0]  est;
      logic [BackW-1:0] back;
      logic [BackW-1:0] rem;
      logic             fix;

      // Estimate is floor(p / k) or one below it
      assign est = DblW'(a_p_ff[k]) * DblW'(Recip);

      always_ff @(posedge clock) begin
         if (enable) begin
            b_side_ff[k] <= a_side_ff[k];
            b_p_ff[k]    <= a_p_ff[k];
            b_q_ff[k]    <= est[DblW-1:FracW];
         end
      end

      assign back = BackW'(b_q_ff[k]) * BackW'(KVal);
      assign rem  = BackW'(b_p_ff[k]) - back;
      assign fix  = (rem >= BackW'(KVal));

      always_ff @(posedge clock) begin
         if (enable) begin
            c_side_ff[k] <= b_side_ff[k];
            c_term_ff[k] <= b_q_ff[k] + FracW'(fix);
         end
      end
   end

   // Stage 48: t = exp(-r) >> n, flushed for large exponents
   side_type        last_side;
   logic [AccW-1:0] t_ff;

   assign last_side = a_side_ff[LastK+1];

   always_ff @(posedge clock) begin
      if (enable) begin
         t_ff <= last_side.big ? '0 : last_side.acc >> last_side.n;
      end
   end

   // Stage 49: alpha = (255 * (1 - t)) >> 32
   logic [AccW-1:0]        one_minus;
   logic [AccW+ColorW-1:0] scaled;
   logic [ColorW-1:0]      alpha_ff;

   assign one_minus = voe_pkg::Q_ONE - t_ff;
   assign scaled    = {one_minus, {ColorW{1'b0}}} - {{ColorW{1'b0}}, one_minus};

   always_ff @(posedge clock) begin
      if (enable) begin
         alpha_ff <= scaled[FracW+ColorW-1:FracW];
      end
   end

   assign alpha = alpha_ff;

endmodule

>>> hw/rtl/voe_skid.sv
// Two-entry output buffer between the shader pipeline and the rsp channel.
// Depends on voe_pkg; ready depends on registered fill only.
`timescale 1ns / 1ps

module voe_skid (
   input  logic                  clock,
   input  logic                  reset,
   input  voe_pkg::voe_push_type push,
   output logic                  ready,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output voe_pkg::voe_rsp_type  rsp_data
);

   logic [1:0]           count_ff;
   logic [1:0]           count_in;
   voe_pkg::voe_rsp_type slot0_ff;
   voe_pkg::voe_rsp_type slot0_in;
   voe_pkg::voe_rsp_type slot1_ff;
   voe_pkg::voe_rsp_type slot1_in;
   logic                 pop;

   assign pop = rsp_valid && !rsp_stall;

   // Next fill and slot contents; slot0 is the head
   always_comb begin
      count_in = count_ff;
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      case ({push.valid, pop})
         2'b10: begin
            if (count_ff == 2'd0) begin
               slot0_in = push.data;
            end else begin
               slot1_in = push.data;
            end
            count_in = count_ff + 2'd1;
         end
         2'b01: begin
            slot0_in = slot1_ff;
            count_in = count_ff - 2'd1;
         end
         2'b11: begin
            // only with one entry held: head leaves, new entry takes its place
            slot0_in = push.data;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

   assign ready     = (count_ff != voe_pkg::SKID_DEPTH);
   assign rsp_valid = (count_ff != 2'd0);
   assign rsp_data  = slot0_ff;

endmodule

>>> hw/rtl/voe_checker.sv
// Port-level checks of the voxel opacity/error shader, bound to the top level.
// Depends on voe_pkg and voxel_opacity_error_shader_defines.svh.
`timescale 1ns / 1ps
`include "voxel_opacity_error_shader_defines.svh"

module voe_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_stall,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input voe_pkg::voe_rsp_type rsp_data
);

   logic [8:0] err_sum;

   assign err_sum = 9'(rsp_data.red) + 9'(rsp_data.blue);

   // A stalled result transaction stays and holds its payload
   `VOE_ASSERT_RST(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid)
   `VOE_ASSERT_RST(a_rsp_stable, clock, reset, rsp_valid && rsp_stall |=> $stable(rsp_data))

   // Reset leaves no result behind
   `VOE_ASSERT_CLK(a_reset_empty, clock, reset |=> !rsp_valid)

   // Input is held off only while the output buffer holds a result
   `VOE_ASSERT_RST(a_stall_full, clock, reset, req_stall |-> rsp_valid)

   // red + blue is 255, or 254 when the error is not a whole multiple of 1/255
   `VOE_ASSERT_RST(a_err_sum, clock, reset, rsp_valid |-> (err_sum == 9'd255 || err_sum == 9'd254))

endmodule

bind voxel_opacity_error_shader voe_checker u_voe_checker (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

>>> tb/sv/tb_top.sv
// Self-checking bench for voxel_opacity_error_shader: streams voxels, predicts each pixel.
// Depends on voe_pkg and the shader RTL; holds its own pixel predictor and scoreboard.
`timescale 1ns / 1ps

module tb_top;

   localparam int PIPE_LAT    = 49;   // req transaction to rsp_valid
   localparam int HOLD_CYCLES = 400;  // long receiver hold-off, fills the pipe
   localparam int PHASE_ITEMS = 180;
   localparam int NUM_PHASES  = 6;

   // Pixel predictor plus the queue of pixels still owed by the shader
   class voxel_shade_board;
      localparam bit [63:0] LN2_FIX = 64'd2977044472;  // ln 2 in Q0.32
      localparam bit [63:0] ONE_FIX = 64'h1_0000_0000;

      voe_pkg::voe_rsp_type pending_pixels[$];
      logic [23:0]          march_len;
      int                   mismatches;

      function new();
         march_len  = 24'd65536;
         mismatches = 0;
      endfunction

      // exp(-x), x in Q16.32, result in Q0.32
      function bit [63:0] exp_neg_fixed(bit [63:0] x);
         bit [63:0] n, rem, acc, term;
         n   = x / LN2_FIX;
         rem = x - n * LN2_FIX;
         if (n >= 64'd33) begin
            return 64'd0;
         end
         acc  = ONE_FIX;
         term = ONE_FIX;
         for (int k = 1; k <= 14; k++) begin
            term = ((term * rem) >> 32) / 64'(k);
            if (k % 2 == 1) begin
               acc = acc - term;
            end else begin
               acc = acc + term;
            end
         end
         return acc >> n;
      endfunction

      function voe_pkg::voe_rsp_type shade_voxel(voe_pkg::voe_req_type v);
         bit [63:0]            dens, refd, diff, t, q;
         voe_pkg::voe_rsp_type px;
         dens = 64'(v.density);
         refd = 64'(v.reference);
         diff = (dens > refd) ? dens - refd : refd - dens;
         // relative error colors; a zero reference saturates unless both are zero
         if (refd == 64'd0) begin
            px.red  = (diff == 64'd0) ? 8'h00 : 8'hFF;
            px.blue = (diff == 64'd0) ? 8'hFF : 8'h00;
         end else begin
            q       = (64'd255 * diff) / refd;
            px.red  = (q > 64'd255) ? 8'hFF : q[7:0];
            q       = (64'd255 * (refd - diff)) / refd;
            px.blue = (diff < refd) ? q[7:0] : 8'h00;
         end
         // opacity from the fixed-point exponential
         t = exp_neg_fixed(dens * 64'(march_len));
         q = (64'd255 * (ONE_FIX - t)) >> 32;
         px.alpha    = (q > 64'd255) ? 8'hFF : q[7:0];
         px.last_out = v.last_voxel;
         return px;
      endfunction

      function void note_voxel(voe_pkg::voe_req_type v);
         pending_pixels = {pending_pixels, shade_voxel(v)};
      endfunction

      function void check_pixel(voe_pkg::voe_rsp_type got);
         voe_pkg::voe_rsp_type want;
         if (pending_pixels.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("%0t: unexpected pixel r=%0d b=%0d a=%0d last=%0d", $time,
                        got.red, got.blue, got.alpha, got.last_out);
            end
            return;
         end
         want = pending_pixels.pop_front();
         if (got.red !== want.red || got.blue !== want.blue ||
             got.alpha !== want.alpha || got.last_out !== want.last_out) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("%0t: pixel mismatch exp r=%0d b=%0d a=%0d last=%0d", $time,
                        want.red, want.blue, want.alpha, want.last_out);
               $display("%0t:                got r=%0d b=%0d a=%0d last=%0d", $time,
                        got.red, got.blue, got.alpha, got.last_out);
            end
         end
      endfunction
   endclass

   logic                         clock = 1'b0;
   logic                         reset;
   logic                         req_valid;
   logic                         req_stall;
   voe_pkg::voe_req_type         req_data;
   logic                         rsp_valid;
   logic                         rsp_stall;
   voe_pkg::voe_rsp_type         rsp_data;
   logic                         csr_valid;
   logic                         csr_ready;
   logic [voe_pkg::DATA_W-1:0]   csr_data;

   voxel_shade_board    board;
   bit                  squeeze_req = 1'b0;
   int                  steady_left = 0;

   voxel_opacity_error_shader dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Gap before the next voxel: mostly none or short, a few long, runs of none
   function automatic int pick_gap();
      int pick;
      if (steady_left > 0) begin
         steady_left--;
         return 0;
      end
      if ($urandom_range(49, 0) == 0) begin
         steady_left = $urandom_range(60, 20);
      end
      pick = $urandom_range(99, 0);
      if (pick < 55) return 0;
      if (pick < 85) return $urandom_range(3, 1);
      if (pick < 97) return $urandom_range(10, 4);
      return $urandom_range(30, 15);
   endfunction

   // Starts and ends at a falling edge; notes the voxel once the shader takes it
   task automatic send_voxel(input voe_pkg::voe_req_type item);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
      board.note_voxel(item);
      @(negedge clock);
   endtask

   task automatic send_pair(input logic [23:0] d, input logic [23:0] r, input logic last);
      voe_pkg::voe_req_type item;
      item.density    = d;
      item.reference  = r;
      item.last_voxel = last;
      send_voxel(item);
   endtask

   task automatic wait_drained();
      while (board.pending_pixels.size() > 0) @(posedge clock);
   endtask

   // marching_length update, only with the pipe empty
   task automatic write_march(input logic [23:0] value);
      wait_drained();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      board.march_len = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Random voxel; densities of random magnitude so the opacity curve is covered
   function automatic voe_pkg::voe_req_type rand_voxel(input logic last);
      voe_pkg::voe_req_type v;
      logic [23:0]          d, r;
      int                   w;
      w = $urandom_range(24, 0);
      d = 24'($urandom) & 24'((32'd1 << w) - 32'd1);
      case ($urandom_range(9, 0))
         0: r = 24'd0;
         1: r = d;
         2, 3: r = d + 24'($urandom_range(16, 0)) - 24'd8;
         4: r = d >> $urandom_range(3, 1);
         5: r = d << 1;
         default: begin
            w = $urandom_range(24, 0);
            r = 24'($urandom) & 24'((32'd1 << w) - 32'd1);
         end
      endcase
      v.density    = d;
      v.reference  = r;
      v.last_voxel = last;
      return v;
   endfunction

   // Receiver: random stall runs, plus a long hold-off on request
   initial begin : rsp_side
      int run_left;
      bit run_stall;
      int pick;
      run_left  = 0;
      run_stall = 1'b0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (squeeze_req) begin
            squeeze_req = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
            run_left = 0;
         end
         if (run_left == 0) begin
            pick = $urandom_range(99, 0);
            if (pick < 40) begin
               run_stall = 1'b0;
               run_left  = $urandom_range(40, 1);
            end else if (pick < 85) begin
               run_stall = 1'b1;
               run_left  = $urandom_range(3, 1);
            end else if (pick < 97) begin
               run_stall = 1'b1;
               run_left  = $urandom_range(15, 4);
            end else begin
               run_stall = 1'b1;
               run_left  = $urandom_range(60, 20);
            end
         end
         run_left--;
         rsp_stall <= run_stall;
      end
   end

   // Result monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && !rsp_stall) begin
         board.check_pixel(rsp_data);
      end
   end

   // Watchdog
   initial begin
      #5_000_000;
      $display("FAIL");
      $finish;
   end

   // Stimulus
   initial begin : stim
      logic [23:0] march_plan [NUM_PHASES];
      int          vol_left;
      bit          last;
      board     = new();
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      csr_valid = 1'b0;
      csr_data  = '0;
      march_plan[0] = 24'd65536;  // reset value, never written
      march_plan[1] = 24'h000000;
      march_plan[2] = 24'hFFFFFF;
      march_plan[3] = 24'h000001;
      march_plan[4] = 24'($urandom);
      march_plan[5] = 24'h00B172;
      vol_left = 0;
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      // Directed voxels under marching_length 1.0
      send_pair(24'd0, 24'd0, 1'b0);              // both zero, zero exponent
      send_pair(24'd5, 24'd0, 1'b0);              // zero reference
      send_pair(24'hFFFFFF, 24'd0, 1'b1);
      send_pair(24'd0, 24'hFFFFFF, 1'b0);         // error exactly one
      send_pair(24'hFFFFFF, 24'hFFFFFF, 1'b0);
      send_pair(24'hFFFFFF, 24'd1, 1'b0);         // red saturates
      send_pair(24'd1, 24'hFFFFFF, 1'b0);
      send_pair(24'd200, 24'd100, 1'b0);
      send_pair(24'd300, 24'd100, 1'b0);          // blue saturates at zero
      send_pair(24'd150, 24'd100, 1'b0);
      send_pair(24'd99, 24'd100, 1'b0);
      send_pair(24'd100, 24'd99, 1'b0);
      send_pair(24'd1, 24'd1, 1'b1);
      send_pair(24'd1499061, 24'd1499061, 1'b0);  // largest shift that still counts
      send_pair(24'd1499062, 24'd1499000, 1'b0);  // exponent flushes, alpha 255
      send_pair(24'd45426, 24'd45427, 1'b0);      // no range reduction
      send_pair(24'd45427, 24'd45426, 1'b0);
      send_pair(24'h800000, 24'h400000, 1'b0);
      send_pair(24'h7FFFFF, 24'h800000, 1'b0);
      send_pair(24'h555555, 24'hAAAAAA, 1'b0);
      send_pair(24'hAAAAAA, 24'h555555, 1'b1);

      // Random volumes, one marching_length setting per phase
      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         if (phase > 0) begin
            req_valid <= 1'b0;
            write_march(march_plan[phase]);
         end
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            if (i == 40 && (phase == 2 || phase == 4)) begin
               squeeze_req = 1'b1;
            end
            if (vol_left == 0) begin
               vol_left = $urandom_range(40, 1);
            end
            vol_left--;
            last = (vol_left == 0);
            send_voxel(rand_voxel(last));
         end
      end
      req_valid <= 1'b0;

      wait_drained();
      repeat (PIPE_LAT + 10) @(posedge clock);
      if (board.mismatches == 0 && board.pending_pixels.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

>>> voxel_opacity_error_shader.f
+incdir+hw/rtl
hw/rtl/voe_pkg.sv
hw/rtl/voe_err.sv
hw/rtl/voe_exp.sv
hw/rtl/voe_skid.sv
hw/rtl/voxel_opacity_error_shader.sv
hw/rtl/voe_checker.sv
tb/sv/tb_top.sv
